// ===== rtl/core/sha_pkg.sv =====
// sha_pkg: shared types, constants and round functions for the sha-256 byte hasher
// no dependencies
package sha_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_ROUNDS,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[t];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha_queue.sv =====
// sha_queue: small fifo between the front and back parts
// depends on sha_pkg
module sha_queue #(
  parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sha_pkg::in_item_t wr_item,
  output logic             full,
  input  logic             rd_en,
  output sha_pkg::in_item_t rd_item,
  output logic             not_empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_pkg::in_item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_item   = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

// ===== rtl/core/sha_front.sv =====
// sha_front: accepts items, drops empty ones, writes the rest into the queue
// depends on sha_pkg
module sha_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_wr
);
  // items with no byte and no end mark change nothing
  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full && (in_data.has_byte || in_data.end_of_message);
endmodule

// ===== rtl/core/sha_back.sv =====
// sha_back: block buffer, padding, 64-round compression and digest output
// depends on sha_pkg
module sha_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sha_pkg::in_item_t  q_item,
  output logic               q_rd,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);
  sha_pkg::back_state_t st_r, st_nxt;
  logic [511:0] blk_r, blk_nxt;       // 16 schedule words, w[t] at the top
  logic [255:0] h_r, h_nxt, v_r, v_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic [5:0]   t_r, t_nxt;
  logic         fin_r, fin_nxt;       // rounds belong to the finish sequence
  logic         two_r, two_nxt;       // another padded block still to come
  logic [1:0]   wi_r, wi_nxt;

  logic [5:0]  pos;
  logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn;
  logic [511:0] byte_blk, pad_blk;

  assign pos = bits_r[8:3];
  assign {a, b, c, d, e, f, g, h} = v_r;
  assign w0 = blk_r[511:480];
  assign t1 = h + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
            + ((e & f) ^ (~e & g)) + sha_pkg::round_k(t_r) + w0;
  assign t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));
  assign s0 = sha_pkg::ror(blk_r[479:448], 7) ^ sha_pkg::ror(blk_r[479:448], 18)
            ^ (blk_r[479:448] >> 3);
  assign s1 = sha_pkg::ror(blk_r[63:32], 17) ^ sha_pkg::ror(blk_r[63:32], 19)
            ^ (blk_r[63:32] >> 10);
  assign wn = w0 + s0 + blk_r[223:192] + s1;

  // byte write at the fill position, and pad byte with zeros after it
  always_comb begin
    byte_blk = blk_r;
    byte_blk[511 - 8*pos -: 8] = q_item.data_byte;
    pad_blk = blk_r;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == pos) pad_blk[511 - 8*i -: 8] = sha_pkg::PAD_BYTE;
      else if (6'(i) > pos) pad_blk[511 - 8*i -: 8] = 8'h00;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sha_pkg::ST_TAKE:
        if (q_valid) begin
          if (q_item.has_byte && pos == 6'd63) st_nxt = sha_pkg::ST_ROUNDS;
          else if (q_item.end_of_message) st_nxt = sha_pkg::ST_PAD;
        end
      sha_pkg::ST_ROUNDS:
        if (t_r == 6'd63) begin
          if (!fin_r) st_nxt = sha_pkg::ST_TAKE;
          else if (two_r) st_nxt = sha_pkg::ST_PAD;
          else st_nxt = sha_pkg::ST_EMIT;
        end
      sha_pkg::ST_PAD: st_nxt = sha_pkg::ST_ROUNDS;
      sha_pkg::ST_EMIT:
        if (!out_stall && wi_r == 2'd3) st_nxt = sha_pkg::ST_TAKE;
      default: st_nxt = sha_pkg::ST_TAKE;
    endcase
  end

  // datapath updates
  always_comb begin
    blk_nxt = blk_r; h_nxt = h_r; v_nxt = v_r; bits_nxt = bits_r;
    t_nxt = t_r; fin_nxt = fin_r; two_nxt = two_r; wi_nxt = wi_r;
    q_rd = 1'b0;
    unique case (st_r)
      sha_pkg::ST_TAKE:
        if (q_valid) begin
          if (q_item.has_byte) begin
            blk_nxt = byte_blk;
            bits_nxt = bits_r + 64'd8;
            if (pos == 6'd63) begin
              // a full block with an end mark runs first, then pads from position zero
              v_nxt = h_r; t_nxt = '0;
              fin_nxt = q_item.end_of_message;
              two_nxt = q_item.end_of_message;
              q_rd = 1'b1;
            end else begin
              q_rd = !q_item.end_of_message;
            end
          end else begin
            q_rd = 1'b0;
          end
          if (q_item.end_of_message && !(q_item.has_byte && pos == 6'd63)) begin
            q_rd = 1'b1;
            fin_nxt = 1'b1;
            two_nxt = 1'b0;
            blk_nxt = q_item.has_byte ? byte_blk : blk_r;
          end
        end
      sha_pkg::ST_PAD: begin
        // overflowing pad takes a second block of zeros plus length
        v_nxt = h_r; t_nxt = '0; fin_nxt = 1'b1;
        if (two_r && pos >= 6'd56) begin
          blk_nxt = {448'd0, bits_r}; two_nxt = 1'b0;
        end else if (!two_r && pos >= 6'd56) begin
          blk_nxt = pad_blk; two_nxt = 1'b1;
        end else begin
          blk_nxt = {pad_blk[511:64], bits_r}; two_nxt = 1'b0;
        end
      end
      sha_pkg::ST_ROUNDS: begin
        v_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
        blk_nxt = {blk_r[479:0], wn};
        t_nxt = t_r + 6'd1;
        if (t_r == 6'd63) begin
          for (int i = 0; i < 8; i++)
            h_nxt[255 - 32*i -: 32] = h_r[255 - 32*i -: 32] + v_nxt[255 - 32*i -: 32];
          wi_nxt = '0;
        end
      end
      sha_pkg::ST_EMIT:
        if (!out_stall) begin
          wi_nxt = wi_r + 2'd1;
          if (wi_r == 2'd3) begin
            h_nxt = sha_pkg::INIT_H; bits_nxt = '0;
          end
        end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = (st_r == sha_pkg::ST_EMIT);
    out_data.digest_word = h_r[255 - 64*wi_r -: 64];
    out_data.word_index  = wi_r;
    out_data.last_word   = (wi_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sha_pkg::ST_TAKE; h_r <= sha_pkg::INIT_H; bits_r <= '0;
      fin_r <= 1'b0; two_r <= 1'b0; wi_r <= '0; t_r <= '0;
    end else begin
      st_r <= st_nxt; h_r <= h_nxt; bits_r <= bits_nxt;
      fin_r <= fin_nxt; two_r <= two_nxt; wi_r <= wi_nxt; t_r <= t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt; v_r <= v_nxt;
  end
endmodule

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// sha256_byte_stream_hasher_core: top level of the sha-256 byte stream hasher
// depends on sha_pkg, sha_front, sha_queue, sha_back
//
// Takes one message byte per beat and returns the sha-256 digest as four 64-bit
// big-endian beats after the end mark. Bytes are taken one per cycle into the
// block buffer unless rounds or output are under way; the 64th byte of a block
// starts the rounds in a single shared round unit, as new beats wait in a four-entry
// queue. An end mark costs one or two padded blocks and then four output beats.
module sha256_byte_stream_hasher_core #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);
  logic q_full, q_wr, q_rd, q_ne;
  sha_pkg::in_item_t q_item;

  sha_front u_front (.in_valid, .in_stall, .in_data, .q_full, .q_wr);

  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_item(in_data), .full(q_full),
    .rd_en(q_rd), .rd_item(q_item), .not_empty(q_ne)
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_item, .q_rd, .out_valid, .out_stall, .out_data
  );
endmodule
